FILE: rtl/vsm_pkg.sv
// ----------------------------------------------------------------------------
// vsm_pkg: shared types and constants
// Beat types, register indexes and sizing constants for the masked box
// smoother.
// ----------------------------------------------------------------------------
package vsm_pkg;

  localparam int MAX_DIM_X = 256;
  localparam int MAX_DIM_Y = 256;
  localparam int XA_W      = $clog2(MAX_DIM_X);
  localparam int YA_W      = $clog2(MAX_DIM_Y);
  localparam int PLANE_DEPTH = 3 * MAX_DIM_X * MAX_DIM_Y;
  localparam int PLANE_AW    = $clog2(PLANE_DEPTH);
  localparam int SUM_W       = 21;   // 27 * 65535 fits
  localparam int CNT_W       = 5;    // up to 27 taps
  localparam int TAPS        = 27;
  localparam int CENTER_TAP  = 13;

  typedef enum logic [2:0] {
    REG_DIM_X       = 3'd0,
    REG_DIM_Y       = 3'd1,
    REG_DIM_Z       = 3'd2,
    REG_NEAR_LIMIT  = 3'd3,
    REG_VALID_LIMIT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] voxel_value;
    logic        first_voxel;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  center_x;
    logic [7:0]  center_y;
    logic [11:0] center_z;
    logic [15:0] smoothed_value;
    logic        last_interior;
  } out_beat_t;

  // Classified voxel passed from the front to the back.
  typedef struct packed {
    logic [15:0]     value;
    logic [XA_W-1:0] x;
    logic [YA_W-1:0] y;
    logic [11:0]     z;
    logic [1:0]      zm;     // z mod 3
    logic            emit;
    logic            last;
  } item_t;

endpackage

FILE: rtl/vsm_ram.sv
// ----------------------------------------------------------------------------
// vsm_ram: generic memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/vsm_front.sv
// ----------------------------------------------------------------------------
// vsm_front: raster position tracker
// Tracks the voxel position, decides whether a voxel closes an interior
// window and whether it is the last one of the volume.
// ----------------------------------------------------------------------------
module vsm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  vsm_pkg::in_beat_t   in_beat,
  input  logic [8:0]          dx,
  input  logic [8:0]          dy,
  input  logic [11:0]         dz,
  output vsm_pkg::item_t      item
);
  import vsm_pkg::*;

  logic [XA_W-1:0] pos_x, pos_x_next;
  logic [YA_W-1:0] pos_y, pos_y_next;
  logic [11:0]     pos_z, pos_z_next;
  logic [1:0]      pos_zm, pos_zm_next;
  logic [XA_W-1:0] x;
  logic [YA_W-1:0] y;
  logic [11:0]     z;
  logic [1:0]      zm;
  logic            x_end, y_end, z_end;

  always_comb begin
    x  = in_beat.first_voxel ? '0 : pos_x;
    y  = in_beat.first_voxel ? '0 : pos_y;
    z  = in_beat.first_voxel ? '0 : pos_z;
    zm = in_beat.first_voxel ? '0 : pos_zm;

    x_end = ({1'b0, x} + 9'd1) >= dx;
    y_end = ({1'b0, y} + 9'd1) >= dy;
    z_end = ({1'b0, z} + 13'd1) >= {1'b0, dz};

    item.value = in_beat.voxel_value;
    item.x     = x;
    item.y     = y;
    item.z     = z;
    item.zm    = zm;
    item.emit  = (x >= XA_W'(2)) && (y >= YA_W'(2)) && (z >= 12'd2);
    item.last  = ({1'b0, x} == dx - 9'd1) && ({1'b0, y} == dy - 9'd1) &&
                 (z == dz - 12'd1);

    pos_x_next  = x + XA_W'(1);
    pos_y_next  = y;
    pos_z_next  = z;
    pos_zm_next = zm;
    if (x_end) begin
      pos_x_next = '0;
      if (y_end) begin
        pos_y_next = '0;
        if (z_end) begin
          pos_z_next  = '0;
          pos_zm_next = '0;
        end else begin
          pos_z_next  = z + 12'd1;
          pos_zm_next = (zm == 2'd2) ? 2'd0 : zm + 2'd1;
        end
      end else begin
        pos_y_next = y + YA_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x  <= '0;
      pos_y  <= '0;
      pos_z  <= '0;
      pos_zm <= '0;
    end else if (take) begin
      pos_x  <= pos_x_next;
      pos_y  <= pos_y_next;
      pos_z  <= pos_z_next;
      pos_zm <= pos_zm_next;
    end
  end

endmodule

FILE: rtl/vsm_mid_q.sv
// ----------------------------------------------------------------------------
// vsm_mid_q: front-to-back queue
// Four-entry register queue of classified voxels.
// ----------------------------------------------------------------------------
module vsm_mid_q (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  vsm_pkg::item_t wr_item,
  output logic           full,
  input  logic           rd,
  output vsm_pkg::item_t rd_item,
  output logic           empty
);
  import vsm_pkg::*;

  item_t      slots [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;

  assign full    = (cnt == 3'd4);
  assign empty   = (cnt == 3'd0);
  assign rd_item = slots[rp];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      slots[wp] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr && !full) begin
        wp <= wp + 2'd1;
      end
      if (rd && !empty) begin
        rp <= rp + 2'd1;
      end
      cnt <= cnt + {2'b0, wr && !full} - {2'b0, rd && !empty};
    end
  end

endmodule

FILE: rtl/vsm_back.sv
// ----------------------------------------------------------------------------
// vsm_back: window engine
// Writes each voxel into the plane store; for a voxel that closes a window
// it gathers the 27-tap window one read per cycle, divides the masked sum by
// a restoring divider (or passes the centre on when it exceeds near_limit or
// no tap is valid) and queues the result in a two-entry output queue.
module vsm_back (
  input  logic                 clk,
  input  logic                 rst,
  input  vsm_pkg::item_t       q_item,
  input  logic                 q_empty,
  output logic                 q_rd,
  input  logic [15:0]          near_limit,
  input  logic [15:0]          valid_limit,
  output vsm_pkg::out_beat_t   out_beat,
  output logic                 empty,
  input  logic                 pop
);
  import vsm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_FIN  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_PUSH = 5'b10000
  } state_t;

  state_t           state;
  item_t            cur;
  logic [4:0]       tap;
  logic [1:0]       plane, jj, mm;
  logic             rd_pend;
  logic [4:0]       rd_tap;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] cnt;
  logic [15:0]      centre;
  logic [CNT_W-1:0] rem;
  logic [4:0]       div_left;
  logic [15:0]      result;
  logic [CNT_W:0]   rem_shift;
  logic             rem_ge;

  logic                we;
  logic [PLANE_AW-1:0] waddr, raddr;
  logic [15:0]         rdata;
  logic [YA_W-1:0]     row;
  logic [XA_W-1:0]     col;

  out_beat_t  oq [2];
  logic       owp, orp;
  logic [1:0] ocnt;
  logic       opush;

  assign we    = (state == ST_IDLE) && !q_empty;
  assign q_rd  = we;
  assign waddr = PLANE_AW'({q_item.zm, q_item.y, q_item.x});
  assign row   = cur.y - YA_W'(2) + YA_W'(jj);
  assign col   = cur.x - XA_W'(2) + XA_W'(mm);
  assign raddr = PLANE_AW'({plane, row, col});

  vsm_ram #(.WIDTH(16), .DEPTH(PLANE_DEPTH)) u_plane (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (q_item.value),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rem_shift = {rem, sum[SUM_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (state == ST_READ);
      case (state)
        ST_IDLE: begin
          if (!q_empty && q_item.emit) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          if (tap == 5'(TAPS - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!rd_pend) begin
            if (centre <= near_limit && cnt != '0) begin
              state <= ST_DIV;
            end else begin
              state <= ST_PUSH;
            end
          end
        end
        ST_DIV: begin
          if (div_left == 5'd1) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (ocnt != 2'd2) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rd_tap <= tap;
    case (state)
      ST_IDLE: begin
        cur      <= q_item;
        tap      <= '0;
        jj       <= '0;
        mm       <= '0;
        plane    <= (q_item.zm == 2'd2) ? 2'd0 : q_item.zm + 2'd1;
        sum      <= '0;
        cnt      <= '0;
        div_left <= 5'(SUM_W);
        rem      <= '0;
      end
      ST_READ: begin
        tap <= tap + 5'd1;
        if (mm == 2'd2) begin
          mm <= '0;
          if (jj == 2'd2) begin
            jj    <= '0;
            plane <= (plane == 2'd2) ? 2'd0 : plane + 2'd1;
          end else begin
            jj <= jj + 2'd1;
          end
        end else begin
          mm <= mm + 2'd1;
        end
      end
      ST_FIN: begin
        result <= centre;
      end
      ST_DIV: begin
        div_left <= div_left - 5'd1;
        rem      <= rem_ge ? CNT_W'(rem_shift - {1'b0, cnt}) : rem_shift[CNT_W-1:0];
        sum      <= {sum[SUM_W-2:0], rem_ge};
        if (div_left == 5'd1) begin
          result <= {sum[14:0], rem_ge};
        end
      end
      default: begin
      end
    endcase
    if (rd_pend) begin
      if (rd_tap == 5'(CENTER_TAP)) begin
        centre <= rdata;
      end
      if (rdata < valid_limit) begin
        sum <= sum + SUM_W'(rdata);
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // Output queue.
  assign opush    = (state == ST_PUSH) && (ocnt != 2'd2);
  assign empty    = (ocnt == 2'd0);
  assign out_beat = oq[orp];

  always_ff @(posedge clk) begin
    if (opush) begin
      oq[owp].center_x       <= cur.x - XA_W'(1);
      oq[owp].center_y       <= cur.y - YA_W'(1);
      oq[owp].center_z       <= cur.z - 12'd1;
      oq[owp].smoothed_value <= result;
      oq[owp].last_interior  <= cur.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= 1'b0;
      orp  <= 1'b0;
      ocnt <= '0;
    end else begin
      if (opush) begin
        owp <= !owp;
      end
      if (pop && !empty) begin
        orp <= !orp;
      end
      ocnt <= ocnt + {1'b0, opush} - {1'b0, pop && !empty};
    end
  end

endmodule

FILE: rtl/volume_masked_box_smoother_core.sv
// ----------------------------------------------------------------------------
// volume_masked_box_smoother_core: masked 3x3x3 smoothing pass
// Streams a Q8.8 distance volume in raster order and emits one smoothed
// value for every interior voxel.
// ----------------------------------------------------------------------------
// Usage. Voxels enter as beats on in_beat with push/full, x fastest. Set
// first_voxel on voxel (0,0,0) of each volume. Interior results leave on
// out_beat with empty/pop, oldest first, one beat per interior voxel, in
// raster order of their centres; last_interior marks the final one.
// Configuration is written through cfg_wr/cfg_idx/cfg_data while the block
// is idle; register indexes follow reg_idx_t in the package.
//
// Flow. A voxel that closes no interior window is only written into the
// plane store by the back end. A voxel that closes one is written into the
// plane store, its window is read tap by tap through the single read port
// of that store, the last read is collected and the decision taken, the
// bit-serial divider runs its 21 steps when a mean is taken and is skipped
// when the centre passes unchanged, and the result is queued.
// The front end takes beats while its four-entry queue has room, so push
// may run ahead of the back end. Reset clears position, queues, state and
// config registers to their defaults; the plane store is not cleared. When the
// receiver stalls, the two-entry output queue fills, the back end waits,
// then the input queue fills and full is raised.
// ----------------------------------------------------------------------------
module volume_masked_box_smoother_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  vsm_pkg::in_beat_t   in_beat,
  output logic                empty,
  input  logic                pop,
  output vsm_pkg::out_beat_t  out_beat,
  input  logic                cfg_wr,
  input  logic [2:0]          cfg_idx,
  input  logic [15:0]         cfg_data
);
  import vsm_pkg::*;

  logic [8:0]  dim_x, dim_y, dx, dy;
  logic [11:0] dim_z, dz;
  logic [15:0] near_limit, valid_limit;
  item_t       f_item, q_item;
  logic        take, q_empty, q_rd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_x       <= 9'd256;
      dim_y       <= 9'd256;
      dim_z       <= 12'd256;
      near_limit  <= 16'd77;
      valid_limit <= 16'd12800;
    end else if (cfg_wr) begin
      case (reg_idx_t'(cfg_idx))
        REG_DIM_X:       dim_x       <= cfg_data[8:0];
        REG_DIM_Y:       dim_y       <= cfg_data[8:0];
        REG_DIM_Z:       dim_z       <= cfg_data[11:0];
        REG_NEAR_LIMIT:  near_limit  <= cfg_data;
        REG_VALID_LIMIT: valid_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Out-of-range dimensions act as the nearest legal size.
  assign dx = (dim_x < 9'd3) ? 9'd3 : (dim_x > 9'(MAX_DIM_X)) ? 9'(MAX_DIM_X) : dim_x;
  assign dy = (dim_y < 9'd3) ? 9'd3 : (dim_y > 9'(MAX_DIM_Y)) ? 9'(MAX_DIM_Y) : dim_y;
  assign dz = (dim_z < 12'd3) ? 12'd3 : dim_z;

  assign take = push && !full;

  vsm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_beat (in_beat),
    .dx      (dx),
    .dy      (dy),
    .dz      (dz),
    .item    (f_item)
  );

  vsm_mid_q u_q (
    .clk     (clk),
    .rst     (rst),
    .wr      (take),
    .wr_item (f_item),
    .full    (full),
    .rd      (q_rd),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  vsm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_item      (q_item),
    .q_empty     (q_empty),
    .q_rd        (q_rd),
    .near_limit  (near_limit),
    .valid_limit (valid_limit),
    .out_beat    (out_beat),
    .empty       (empty),
    .pop         (pop)
  );

  // A voxel flagged as the start of a volume can never close a window.
  a_first_no_emit: assert property (@(posedge clk) disable iff (rst)
    take && in_beat.first_voxel |-> !f_item.emit)
    else $error("first voxel classified as interior");

  // Every emitted centre lies off the low boundary of the volume (no coordinate is zero).
  a_center_interior: assert property (@(posedge clk) disable iff (rst)
    !empty |-> out_beat.center_x != 8'd0 && out_beat.center_y != 8'd0 &&
               out_beat.center_z != 12'd0)
    else $error("emitted centre on the boundary");

  // The back end drains the queue only when it holds something.
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> !q_empty)
    else $error("queue read while empty");

endmodule
